/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/apd_pkg.sv */
// Shared constants for the attractor period detector
package apd_pkg;

    localparam int GENES_DEF      = 32;
    localparam int HIST_DEPTH_DEF = 256;

    localparam int STATE_W  = 32;
    localparam int PERIOD_W = 9;
    localparam int LIMIT_W  = 8;

    localparam logic [LIMIT_W-1:0]  STEP_LIMIT_RST = 8'd200;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 9'd511;

endpackage

/* hw/rtl/attractor_period_detector_top.sv */
// Attractor period detector: trajectory memory with a newest-first search
//
// Input channel (in_valid/in_ready) takes one state word per item; first_item
// marks the initial condition and restarts the trajectory. Output channel
// (out_valid/out_ready) returns one word per item: found, period, limit_hit.
// The cfg channel (cfg_valid/cfg_ready, data on step_limit) sets the step
// limit; it is always ready; the user writes it only while the block is idle (not enforced by the block).
//
// Search: the history memory is read one entry a cycle, newest entry first,
// until a match or the oldest entry has been compared; an initial condition
// or an empty trajectory finishes with no read. The history memory has a
// single read port, and a new item is accepted only once the previous
// search has finished.
// A new item is accepted while the previous result still waits in the
// output register; if that register is still occupied when a search ends,
// the block holds the finished result and accepts nothing until it drains.
// Reset empties the trajectory (entry count zero; memory contents are left
// as they are and never read before written) and sets the step limit to 200.
module attractor_period_detector_top
    import apd_pkg::*;
#(
    parameter int GENES      = GENES_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [STATE_W-1:0]  state_bits,
    input  logic                first_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [PERIOD_W-1:0] period,
    output logic                limit_hit,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  step_limit
);

    `include "assert_macros.svh"

    localparam int W  = (GENES < STATE_W) ? GENES : STATE_W;
    localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CW = $clog2(HIST_DEPTH + 1);
    localparam int DW = $clog2(HIST_DEPTH + 2);
    localparam int XW = (DW > PERIOD_W) ? DW : PERIOD_W;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic                found;
        logic [PERIOD_W-1:0] period;
        logic                limit_hit;
    } result_t;

    logic [W-1:0] hist_mem [HIST_DEPTH];
    logic [W-1:0] rd_data_reg;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [W-1:0]   st_reg;
    logic           first_reg;
    logic [DW-1:0]  rd_dist_reg, rd_dist_next;
    logic           cmp_vld_reg, cmp_vld_next;
    logic [DW-1:0]  cmp_dist_reg, cmp_dist_next;
    logic [LIMIT_W-1:0] limit_reg;
    result_t        pend_reg, pend_next;
    result_t        res_reg;
    logic           out_valid_reg, out_valid_next;

    logic           in_acc;
    logic [CW-1:0]  base;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic           finish;
    logic           match;
    logic [XW-1:0]  dist_x;
    logic [PERIOD_W-1:0] period_sat;
    logic [CW-1:0]  new_count;
    logic           dropped;
    logic           load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign base = first_reg ? '0 : count_reg;

    assign dist_x     = XW'(cmp_dist_reg);
    assign period_sat = (dist_x > XW'(PERIOD_MAX)) ? PERIOD_MAX : dist_x[PERIOD_W-1:0];

    assign dropped   = (base == CW'(HIST_DEPTH));
    assign new_count = dropped ? base : base + CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_dist_next  = rd_dist_reg;
        cmp_vld_next  = 1'b0;
        cmp_dist_next = cmp_dist_reg;
        pend_next     = pend_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        finish        = 1'b0;
        match         = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next   = ST_SCAN;
                    rd_dist_next = DW'(1);
                end
            end
            ST_SCAN:
            begin
                // issue the next read, newest entry first
                if (DW'(base) >= rd_dist_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = AW'(DW'(base) - rd_dist_reg);
                    cmp_vld_next  = 1'b1;
                    cmp_dist_next = rd_dist_reg;
                    rd_dist_next  = rd_dist_reg + DW'(1);
                end
                if (base == '0)
                begin
                    finish = 1'b1;
                end
                else if (cmp_vld_reg && (rd_data_reg == st_reg))
                begin
                    finish = 1'b1;
                    match  = 1'b1;
                end
                else if (cmp_vld_reg && (cmp_dist_reg == DW'(base)))
                begin
                    finish = 1'b1;
                end
                if (finish)
                begin
                    wr_en            = !dropped;
                    count_next       = new_count;
                    pend_next.found  = match;
                    pend_next.period = match ? period_sat : '0;
                    pend_next.limit_hit = dropped || (LW'(new_count) > LW'(limit_reg));
                    state_next       = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[AW'(base)] <= st_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st_reg    <= state_bits[W-1:0];
            first_reg <= first_item;
        end
        rd_dist_reg  <= rd_dist_next;
        cmp_dist_reg <= cmp_dist_next;
        pend_reg     <= pend_next;
        if (load_out)
        begin
            res_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= STEP_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= step_limit;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = res_reg.found;
    assign period    = res_reg.period;
    assign limit_hit = res_reg.limit_hit;

    `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(HIST_DEPTH))
    `ASSERT_IMP(a_no_match_zero, clk, rst_n, out_valid_reg && !found, period == '0)
    `ASSERT_IMP(a_match_nonzero, clk, rst_n, out_valid_reg && found, period != '0)
    `ASSERT_NXT(a_finish_done, clk, rst_n, finish, state_reg == ST_DONE)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for attractor_period_detector_top: directed table, random trajectories
`timescale 1ns / 1ps

module tb_top;
    import apd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          ITEM_TARGET = 1120;
    localparam int          LONG_RUN    = 300;

    typedef struct packed {
        logic                found;
        logic [PERIOD_W-1:0] period;
        logic                limit_hit;
    } apd_word_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [STATE_W-1:0] data;
        logic               first;
        bit                 typed;
        apd_word_t          want;
    } stim_row_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [STATE_W-1:0]  state_bits = '0;
    logic                first_item = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                found;
    logic [PERIOD_W-1:0] period;
    logic                limit_hit;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  step_limit = STEP_LIMIT_RST;

    // predictor state
    logic [STATE_W-1:0]  traj_mem [HIST_DEPTH_DEF];
    int unsigned         traj_len;
    logic [LIMIT_W-1:0]  limit_model;

    apd_word_t           pending_words [$];
    apd_word_t           got_word;
    apd_word_t           want_word;
    int unsigned         mismatches = 0;
    int unsigned         items_sent = 0;
    int unsigned         cycles     = 0;
    bit                  calm       = 1'b0;
    bit                  hold_req   = 1'b0;
    bit                  hold_taken = 1'b0;
    int unsigned         hold_left  = 0;

    attractor_period_detector_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .state_bits (state_bits),
        .first_item (first_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .period     (period),
        .limit_hit  (limit_hit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .step_limit (step_limit)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic apd_word_t word(input int unsigned f, input int unsigned p,
                                       input int unsigned l);
        apd_word_t w;
        w.found     = f[0];
        w.period    = p[PERIOD_W-1:0];
        w.limit_hit = l[0];
        return w;
    endfunction

    // Search newest to oldest, then append unless the trajectory is full
    function automatic apd_word_t advance_trajectory(input logic [STATE_W-1:0] s,
                                                     input logic f);
        apd_word_t   r;
        bit          dropped;
        int unsigned d;
        r       = '0;
        dropped = 1'b0;
        if (f)
            traj_len = 0;
        else
        begin
            for (d = 1; d <= traj_len && !r.found; d++)
            begin
                if (traj_mem[traj_len - d] == s)
                begin
                    r.found  = 1'b1;
                    r.period = (d > PERIOD_MAX) ? PERIOD_MAX : d[PERIOD_W-1:0];
                end
            end
        end
        if (traj_len < HIST_DEPTH_DEF)
        begin
            traj_mem[traj_len] = s;
            traj_len++;
        end
        else
            dropped = 1'b1;
        r.limit_hit = dropped || (traj_len > limit_model);
        return r;
    endfunction

    function automatic logic [STATE_W-1:0] rand_state(input bit narrow);
        logic [STATE_W-1:0] s;
        s = $urandom;
        if (narrow)
            s = s & 32'h7;
        return s;
    endfunction

    function automatic void compare_field(input string tag, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, tag, want, got);
        end
    endfunction

    // Receiver: random back-pressure, one long hold-off, check each word taken
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got_word = {found, period, limit_hit};
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected word: expected none, got %0h", $time, got_word);
                end
                else
                begin
                    want_word = pending_words.pop_front();
                    compare_field("found", 32'(want_word.found), 32'(got_word.found));
                    compare_field("period", 32'(want_word.period), 32'(got_word.period));
                    compare_field("limit_hit", 32'(want_word.limit_hit),
                                  32'(got_word.limit_hit));
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    // Offer one word; return at the edge where it is taken
    task automatic offer_word(input logic [STATE_W-1:0] s, input logic f, input bit typed,
                              input apd_word_t want);
        apd_word_t guess;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        state_bits <= s;
        first_item <= f;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        guess = advance_trajectory(s, f);
        pending_words.push_back(typed ? want : guess);
        items_sent++;
    endtask

    // Drop valid and hold until every word has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid  <= 1'b1;
        step_limit <= v;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        cfg_valid   <= 1'b0;
        limit_model  = v;
    endtask

    // One trajectory: transient, then a cycle walked a few laps; some are broken, some a single random word
    task automatic run_trajectory();
        logic [STATE_W-1:0] walk [$];
        logic [STATE_W-1:0] loop_st [12];
        int                 roll;
        int                 pre;
        int                 cyc;
        int                 laps;
        int                 k;
        bit                 narrow;
        bit                 lead_first;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            offer_word(rand_state($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                       1'b0, '0);
            return;
        end
        narrow     = ($urandom_range(0, 3) == 0);
        lead_first = 1'b1;
        pre        = $urandom_range(0, 12);
        cyc        = $urandom_range(1, 12);
        laps       = $urandom_range(1, 3);
        walk.delete();
        walk.push_back(rand_state(narrow));
        for (k = 0; k < pre; k++)
            walk.push_back(rand_state(narrow));
        for (k = 0; k < cyc; k++)
            loop_st[k] = rand_state(narrow);
        for (k = 0; k < cyc * laps + $urandom_range(0, cyc); k++)
            walk.push_back(loop_st[k % cyc]);
        if (roll < 15)
            walk[$urandom_range(0, walk.size() - 1)] = rand_state(1'b0);
        else if (roll < 20)
            lead_first = 1'b0;
        else if (roll < 25)
            walk = walk[0:$urandom_range(0, walk.size() - 1)];
        for (k = 0; k < walk.size(); k++)
            offer_word(walk[k], (k == 0) && lead_first, 1'b0, '0);
    endtask

    initial
    begin
        stim_row_t          plan [$];
        logic [STATE_W-1:0] long_pool [LONG_RUN];
        logic [LIMIT_W-1:0] extremes [4];
        int                 i;
        int                 phase;
        int unsigned        next_switch;

        traj_len    = 0;
        limit_model = STEP_LIMIT_RST;

        // empty history first, then initial conditions, fixed points, cycles
        plan.push_back('{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, word(0, 0, 0)});
        plan.push_back('{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, word(1, 1, 0)});
        plan.push_back('{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1, word(0, 0, 0)});
        plan.push_back('{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, word(1, 1, 0)});
        plan.push_back('{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b1, word(0, 0, 0)});
        plan.push_back('{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, word(0, 0, 0)});
        plan.push_back('{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1, word(1, 3, 0)});
        plan.push_back('{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b1, word(1, 3, 0)});
        plan.push_back('{ROW_ITEM, 32'hA5A5_A5A5, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'h5A5A_5A5A, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'hA5A5_A5A5, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'h5A5A_5A5A, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'hA5A5_A5A4, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG,  32'd1,         1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'h1234_5678, 1'b1, 1'b1, word(0, 0, 0)});
        plan.push_back('{ROW_ITEM, 32'h1234_5678, 1'b0, 1'b1, word(1, 1, 1)});
        plan.push_back('{ROW_ITEM, 32'h1234_5679, 1'b0, 1'b1, word(0, 0, 1)});
        // a limit of zero flags every word, initial condition included
        plan.push_back('{ROW_CFG,  32'd0,         1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'hDEAD_BEEF, 1'b1, 1'b1, word(0, 0, 1)});
        plan.push_back('{ROW_ITEM, 32'hDEAD_BEEF, 1'b0, 1'b1, word(1, 1, 1)});
        plan.push_back('{ROW_CFG,  32'd255,       1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'h0F0F_0F0F, 1'b1, 1'b1, word(0, 0, 0)});
        plan.push_back('{ROW_ITEM, 32'hF0F0_F0F0, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, 32'h0F0F_0F0F, 1'b0, 1'b1, word(1, 2, 0)});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_limit(plan[i].data[LIMIT_W-1:0]);
            end
            else
                offer_word(plan[i].data, plan[i].first, plan[i].typed, plan[i].want);
        end

        // Fill the history past its depth, hit the oldest entry, then probe
        settle();
        write_limit(8'd255);
        for (i = 0; i < LONG_RUN; i++)
        begin
            long_pool[i] = rand_state(1'b0);
            offer_word(long_pool[i], i == 0, 1'b0, '0);
        end
        offer_word(long_pool[0], 1'b0, 1'b0, '0);
        repeat (20)
            offer_word(long_pool[$urandom_range(0, LONG_RUN - 1)], 1'b0, 1'b0, '0);

        extremes[0] = 8'd1;
        extremes[1] = 8'd0;
        extremes[2] = 8'd255;
        extremes[3] = STEP_LIMIT_RST;
        phase       = 0;
        next_switch = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_switch)
            begin
                settle();
                write_limit((phase < 4) ? extremes[phase] : LIMIT_W'($urandom_range(1, 254)));
                if (phase == 0)
                    hold_req <= 1'b1;
                phase++;
                next_switch = items_sent + 150;
            end
            calm <= (items_sent >= 650) && (items_sent < 850);
            run_trajectory();
        end

        settle();
        repeat (HIST_DEPTH_DEF + 16) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
